>>> rtl/core/dfsd_pkg.sv
// Shared types and constants for the dual frame status decoder.
// No dependencies; imported by every module in rtl/core.
package dfsd_pkg;

    localparam int unsigned DefSlaveFrameLen  = 16;
    localparam int unsigned DefMasterFrameLen = 17;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned CountW = 5;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned DataW  = 64;

    // collect modes
    localparam logic [1:0] MODE_HUNT   = 2'd0;
    localparam logic [1:0] MODE_SLAVE  = 2'd1;
    localparam logic [1:0] MODE_MASTER = 2'd2;

    // register indexes
    localparam logic [CfgIdxW-1:0] REG_SLAVE_HEAD  = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_SLAVE_TAIL  = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_MASTER_HEAD = 2'd2;
    localparam logic [CfgIdxW-1:0] REG_MASTER_TAIL = 2'd3;

    localparam logic [ByteW-1:0] RST_SLAVE_HEAD  = 8'd30;
    localparam logic [ByteW-1:0] RST_SLAVE_TAIL  = 8'd205;
    localparam logic [ByteW-1:0] RST_MASTER_HEAD = 8'd104;
    localparam logic [ByteW-1:0] RST_MASTER_TAIL = 8'd43;

    // byte positions within a frame
    localparam int unsigned POS_PHASE    = 2;
    localparam int unsigned POS_COOK     = 3;
    localparam int unsigned POS_S_FLAGS  = 6;
    localparam int unsigned POS_BUZZER   = 7;
    localparam int unsigned POS_BOT_TEMP = 8;
    localparam int unsigned POS_TOP_TEMP = 9;
    localparam int unsigned POS_M_FLAGS  = 10;
    localparam int unsigned POS_IGBT2    = 10;
    localparam int unsigned POS_IGBT1    = 11;
    localparam int unsigned POS_BOT_CUR  = 13;
    localparam int unsigned POS_REAR_CUR = 14;

    localparam logic FRAME_SLAVE  = 1'b0;
    localparam logic FRAME_MASTER = 1'b1;

    typedef struct packed {
        logic [ByteW-1:0] slave_head;
        logic [ByteW-1:0] slave_tail;
        logic [ByteW-1:0] master_head;
        logic [ByteW-1:0] master_tail;
    } t_cfg;

    typedef struct packed {
        logic             frame_kind;
        logic [3:0]       status_flags;
        logic [3:0]       phase_code;
        logic [1:0]       buzzer_code;
        logic [4:0]       cook_type;
        logic [ByteW-1:0] bottom_temp;
        logic [ByteW-1:0] top_temp;
        logic [ByteW-1:0] igbt2_temp;
        logic [ByteW-1:0] igbt1_temp;
        logic [ByteW-1:0] bottom_current;
        logic [ByteW-1:0] rear_current;
    } t_result;

endpackage

>>> rtl/core/dfsd_cfg.sv
// Configuration register file: head and tail bytes of both frame kinds.
// Depends on dfsd_pkg.
module dfsd_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_we,
    input  logic [dfsd_pkg::CfgIdxW-1:0]  i_idx,
    input  logic [dfsd_pkg::ByteW-1:0]    i_data,
    output dfsd_pkg::t_cfg                o_cfg
);
    import dfsd_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_we) begin
            unique case (i_idx)
                REG_SLAVE_HEAD:  n_cfg.slave_head  = i_data;
                REG_SLAVE_TAIL:  n_cfg.slave_tail  = i_data;
                REG_MASTER_HEAD: n_cfg.master_head = i_data;
                REG_MASTER_TAIL: n_cfg.master_tail = i_data;
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slave_head  <= RST_SLAVE_HEAD;
            r_cfg.slave_tail  <= RST_SLAVE_TAIL;
            r_cfg.master_head <= RST_MASTER_HEAD;
            r_cfg.master_tail <= RST_MASTER_TAIL;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/core/dfsd_framer.sv
// Frame hunter: collect mode, byte count and frame store; decodes a
// completed frame in the same cycle as its tail word. Depends on dfsd_pkg.
module dfsd_framer #(
    parameter int unsigned SLAVE_FRAME_LEN  = dfsd_pkg::DefSlaveFrameLen,
    parameter int unsigned MASTER_FRAME_LEN = dfsd_pkg::DefMasterFrameLen
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  logic [dfsd_pkg::ByteW-1:0] i_byte,
    input  dfsd_pkg::t_cfg             i_cfg,
    output logic                       o_hit,
    output dfsd_pkg::t_result          o_result
);
    import dfsd_pkg::*;

    localparam int unsigned StoreDepth =
        (SLAVE_FRAME_LEN > MASTER_FRAME_LEN) ? SLAVE_FRAME_LEN : MASTER_FRAME_LEN;
    localparam logic [CountW-1:0] SlaveLen  = CountW'(SLAVE_FRAME_LEN);
    localparam logic [CountW-1:0] MasterLen = CountW'(MASTER_FRAME_LEN);

    logic [1:0]        r_mode;
    logic [1:0]        n_mode;
    logic [CountW-1:0] r_count;
    logic [CountW-1:0] n_count;
    logic [ByteW-1:0]  r_store [StoreDepth];
    logic [ByteW-1:0]  n_store [StoreDepth];

    logic              wr_head;   // store word at position zero
    logic              wr_data;   // store word at r_count
    logic              hit_slave;
    logic              hit_master;
    logic [CountW-1:0] count_inc;
    logic [1:0]        mode_mid;  // mode after the slave side has run
    logic              stop;      // slave side consumed the word

    assign count_inc = r_count + CountW'(1);

    always_comb begin
        n_mode     = r_mode;
        n_count    = r_count;
        wr_head    = 1'b0;
        wr_data    = 1'b0;
        hit_slave  = 1'b0;
        hit_master = 1'b0;
        stop       = 1'b0;
        mode_mid   = (r_mode == MODE_SLAVE || r_mode == MODE_MASTER) ? r_mode : MODE_HUNT;

        // slave side
        if (mode_mid == MODE_HUNT) begin
            if (i_byte == i_cfg.slave_head) begin
                n_mode  = MODE_SLAVE;
                n_count = CountW'(1);
                wr_head = 1'b1;
                stop    = 1'b1;
            end
        end else if (mode_mid == MODE_SLAVE) begin
            wr_data = 1'b1;
            if (count_inc >= SlaveLen) begin
                hit_slave = (i_byte == i_cfg.slave_tail);
                mode_mid  = MODE_HUNT;
                n_mode    = MODE_HUNT;
                n_count   = '0;
            end else begin
                n_count = count_inc;
                stop    = 1'b1;
            end
        end

        // master side; a word closing a slave frame may open a master one
        if (!stop) begin
            if (mode_mid == MODE_HUNT) begin
                if (i_byte == i_cfg.master_head) begin
                    n_mode  = MODE_MASTER;
                    n_count = CountW'(1);
                    wr_head = 1'b1;
                end
            end else if (mode_mid == MODE_MASTER) begin
                wr_data = 1'b1;
                if (count_inc >= MasterLen) begin
                    hit_master = (i_byte == i_cfg.master_tail);
                    n_mode     = MODE_HUNT;
                    n_count    = '0;
                end else begin
                    n_count = count_inc;
                end
            end
        end
    end

    always_comb begin
        for (int k = 0; k < StoreDepth; k++) begin
            n_store[k] = r_store[k];
            if ((wr_data && r_count == CountW'(k)) || (wr_head && k == 0)) begin
                n_store[k] = i_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_HUNT;
            r_count <= '0;
        end else if (i_accept) begin
            r_mode  <= n_mode;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            for (int k = 0; k < StoreDepth; k++) begin
                r_store[k] <= n_store[k];
            end
        end
    end

    // fields of the other frame kind are zero
    always_comb begin
        o_result = '0;
        if (hit_master) begin
            o_result.frame_kind     = FRAME_MASTER;
            o_result.status_flags   = n_store[POS_M_FLAGS][3:0];
            o_result.phase_code     = n_store[POS_PHASE][3:0];
            o_result.cook_type      = n_store[POS_COOK][4:0];
            o_result.bottom_current = n_store[POS_BOT_CUR];
            o_result.rear_current   = n_store[POS_REAR_CUR];
        end else begin
            o_result.frame_kind   = FRAME_SLAVE;
            o_result.status_flags = {1'b0, n_store[POS_S_FLAGS][5:3]};
            o_result.phase_code   = {1'b0, n_store[POS_PHASE][7:5]};
            o_result.buzzer_code  = n_store[POS_BUZZER][1:0];
            o_result.bottom_temp  = n_store[POS_BOT_TEMP];
            o_result.top_temp     = n_store[POS_TOP_TEMP];
            o_result.igbt2_temp   = n_store[POS_IGBT2];
            o_result.igbt1_temp   = n_store[POS_IGBT1];
        end
    end

    assign o_hit = i_accept && (hit_slave || hit_master);

    a_slave_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == MODE_SLAVE |-> (r_count < SlaveLen && r_count != '0))
        else $error("slave byte count out of range");

    a_master_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == MODE_MASTER |-> (r_count < MasterLen && r_count != '0))
        else $error("master byte count out of range");

    a_hit_from_collect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hit |-> (r_mode == MODE_SLAVE || r_mode == MODE_MASTER))
        else $error("frame decoded while hunting");

    a_hit_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hit |=> r_mode != $past(r_mode))
        else $error("collect mode kept after a decoded frame");

endmodule

>>> rtl/core/dfsd_out_reg.sv
// Result register with valid/ready handshake towards the downstream side.
// Depends on dfsd_pkg.
module dfsd_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  dfsd_pkg::t_result i_result,
    input  logic              i_m_tready,
    output logic              o_ready,
    output logic              o_m_tvalid,
    output dfsd_pkg::t_result o_result
);
    import dfsd_pkg::*;

    logic    r_valid;
    t_result r_result;

    // new word may enter when the register is empty or drains this cycle
    assign o_ready = !r_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_load) begin
            r_result <= i_result;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_result   = r_result;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_m_tready) |=> (r_valid && $stable(r_result)))
        else $error("pending result overwritten");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ready && i_load) |=> r_valid)
        else $error("loaded result not presented");

    a_drain_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_m_tready && !i_load) |=> !r_valid)
        else $error("taken result presented again");

endmodule

>>> rtl/core/dual_frame_status_decoder.sv
// Channel    | dir | handshake                          | payload
// s_axis     | in  | i_s_axis_tvalid / o_s_axis_tready  | tdata[7:0] rx_byte
// m_axis     | out | o_m_axis_tvalid / i_m_axis_tready  | tdata (decoded fields), tuser kind
// cfg        | in  | i_cfg_we                           | i_cfg_idx, i_cfg_data
//
// One word per cycle; a decoded frame appears on m_axis the cycle after its
// tail word is taken (one register stage after the framer).
// Synchronous active-low reset: hunting, byte count zero, config registers to defaults.
// A stalled output holds its result; input keeps flowing while the result
// register is empty or being drained in the same cycle.
// Depends on dfsd_pkg, dfsd_cfg, dfsd_framer, dfsd_out_reg.
module dual_frame_status_decoder #(
    parameter int unsigned SLAVE_FRAME_LEN  = dfsd_pkg::DefSlaveFrameLen,
    parameter int unsigned MASTER_FRAME_LEN = dfsd_pkg::DefMasterFrameLen
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [dfsd_pkg::ByteW-1:0]    i_s_axis_tdata,  // [7:0] rx_byte
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // [3:0] status_flags, [7:4] phase_code, [9:8] buzzer_code,
    // [14:10] cook_type, [22:15] bottom_temp, [30:23] top_temp,
    // [38:31] igbt2_temp, [46:39] igbt1_temp, [54:47] bottom_current,
    // [62:55] rear_current, [63] zero
    output logic [dfsd_pkg::DataW-1:0]    o_m_axis_tdata,
    output logic                          o_m_axis_tuser,  // [0] frame_kind
    input  logic                          i_cfg_we,
    input  logic [dfsd_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [dfsd_pkg::ByteW-1:0]    i_cfg_data
);
    import dfsd_pkg::*;

    t_cfg    cfg;
    t_result frame_result;
    t_result out_result;
    logic    in_accept;
    logic    frame_hit;
    logic    ready;

    assign o_s_axis_tready = ready;
    assign in_accept       = i_s_axis_tvalid && ready;

    dfsd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    dfsd_framer #(
        .SLAVE_FRAME_LEN  (SLAVE_FRAME_LEN),
        .MASTER_FRAME_LEN (MASTER_FRAME_LEN)
    ) u_framer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_byte   (i_s_axis_tdata),
        .i_cfg    (cfg),
        .o_hit    (frame_hit),
        .o_result (frame_result)
    );

    dfsd_out_reg u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (frame_hit),
        .i_result   (frame_result),
        .i_m_tready (i_m_axis_tready),
        .o_ready    (ready),
        .o_m_tvalid (o_m_axis_tvalid),
        .o_result   (out_result)
    );

    assign o_m_axis_tuser = out_result.frame_kind;
    assign o_m_axis_tdata = {1'b0,
                             out_result.rear_current,
                             out_result.bottom_current,
                             out_result.igbt1_temp,
                             out_result.igbt2_temp,
                             out_result.top_temp,
                             out_result.bottom_temp,
                             out_result.cook_type,
                             out_result.buzzer_code,
                             out_result.phase_code,
                             out_result.status_flags};

endmodule
